[hw/rtl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg: shared types for the round-robin task scheduler
// Command codes, slot status codes, the task table entry and the small
// structs that pass between the controller, the table and the top level.
// ----------------------------------------------------------------------------
package rrts_pkg;

  typedef enum logic [3:0] {
    CMD_TICK       = 4'd0,
    CMD_ALLOC      = 4'd1,
    CMD_PAUSE_TID  = 4'd2,
    CMD_RESUME_TID = 4'd3,
    CMD_TERM_TID   = 4'd4,
    CMD_PAUSE_PID  = 4'd5,
    CMD_RESUME_PID = 4'd6,
    CMD_TERM_PID   = 4'd7,
    CMD_SET_SLEEP  = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_RUN  = 2'd1,
    ST_SUSP = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  // One task table entry
  typedef struct packed {
    logic [15:0] pid;
    logic [31:0] run_count;
    logic [31:0] sleep;
    status_t     status;
  } entry_t;

  // Table port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Result item as handed to the output register
  typedef struct packed {
    logic [15:0] cur_pid;
    logic [5:0]  cur_slot;
    logic [5:0]  hit_slot;
    logic        success;
  } res_t;

endpackage

[hw/rtl/round_robin_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit: round-robin task scheduler with sleep counters
// Flow: tid commands and set sleep read, update and write back one entry;
//   tick, allocate and pid commands walk the task table (one read port, one
//   write port), one entry per cycle, until the first hit or the last entry.
// Throughput: one item at a time; the next item is accepted while a result
//   still waits in the output register.
// Reset: a clearing pass initializes the table (slot 0 running, others
//   free); no item is accepted until it ends.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit #(
  parameter int NUM_TASKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] command, [9:4] task_slot, [25:10] proc_id, [57:26] sleep_ticks,
  // [63:58] zero
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] success, [6:1] hit_slot, [12:7] current_slot, [28:13] current_pid,
  // [31:29] zero
  output logic [31:0] out_tdata
);

  localparam int IDX_W = $clog2(NUM_TASKS);

  rrts_pkg::mem_ctl_t  mem_ctl;
  logic [IDX_W-1:0]    mem_waddr;
  logic [IDX_W-1:0]    mem_raddr;
  rrts_pkg::entry_t    mem_wdata;
  rrts_pkg::entry_t    mem_rdata;

  rrts_pkg::res_t      res;
  logic                res_valid;
  logic                res_ready;

  logic                out_valid_r;
  logic [31:0]         out_data_r;

  // Sequencer: decodes the item and walks the table
  rrts_ctrl #(
    .NUM_TASKS (NUM_TASKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tdata[3:0]),
    .in_slot   (in_tdata[9:4]),
    .in_pid    (in_tdata[25:10]),
    .in_sleep  (in_tdata[57:26]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Task table: status, sleep, run count and pid per slot
  rrts_table #(
    .NUM_TASKS (NUM_TASKS)
  ) u_table (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata   (mem_rdata)
  );

  // Output register: load when empty or being drained, hold while stalled
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= {3'b000, res.cur_pid, res.cur_slot, res.hit_slot, res.success};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/rrts_table.sv]
// ----------------------------------------------------------------------------
// rrts_table: task table memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rrts_table #(
  parameter int NUM_TASKS = 64,
  localparam int IDX_W    = $clog2(NUM_TASKS)
) (
  input  logic                clk,
  input  rrts_pkg::mem_ctl_t  mem_ctl,
  input  logic [IDX_W-1:0]    waddr,
  input  rrts_pkg::entry_t    wdata,
  input  logic [IDX_W-1:0]    raddr,
  output rrts_pkg::entry_t    rdata
);

  rrts_pkg::entry_t mem [NUM_TASKS];
  rrts_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (mem_ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/rrts_ctrl.sv]
// ----------------------------------------------------------------------------
// rrts_ctrl: command sequencer
// Clears the table after reset, then walks table entries one per cycle with
// a read / modify / write-back pipeline for each command.
// ----------------------------------------------------------------------------
module rrts_ctrl #(
  parameter int NUM_TASKS = 64,
  localparam int IDX_W    = $clog2(NUM_TASKS),
  localparam int CNT_W    = $clog2(NUM_TASKS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          in_cmd,
  input  logic [5:0]          in_slot,
  input  logic [15:0]         in_pid,
  input  logic [31:0]         in_sleep,
  output logic                res_valid,
  input  logic                res_ready,
  output rrts_pkg::res_t      res,
  output rrts_pkg::mem_ctl_t  mem_ctl,
  output logic [IDX_W-1:0]    mem_waddr,
  output rrts_pkg::entry_t    mem_wdata,
  output logic [IDX_W-1:0]    mem_raddr,
  input  rrts_pkg::entry_t    mem_rdata
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  rrts_pkg::state_t  state_r, state_nxt;
  rrts_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [15:0]       pid_r, pid_nxt;
  logic [31:0]       sleep_r, sleep_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [15:0]       cur_pid_r, cur_pid_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              first_r, first_nxt;
  logic              pv_r, pv_nxt;
  logic [IDX_W-1:0]  p_addr_r, p_addr_nxt;
  logic              p_first_r, p_first_nxt;
  logic              p_last_r, p_last_nxt;
  logic [IDX_W-1:0]  hit_r, hit_nxt;
  logic              hit_vld_r, hit_vld_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;

  rrts_pkg::cmd_t    in_cmd_e;
  logic              tid_ok;
  rrts_pkg::entry_t  upd;
  logic              upd_wr;
  logic              upd_hit;
  logic              stop;

  assign in_cmd_e = rrts_pkg::cmd_t'(in_cmd);
  assign tid_ok   = 32'(in_slot) < 32'(NUM_TASKS);

  // Per-entry rule of the current command on the entry just read
  always_comb begin
    upd     = mem_rdata;
    upd_wr  = 1'b0;
    upd_hit = 1'b0;
    case (cmd_r) inside
      rrts_pkg::CMD_TICK: begin
        if (mem_rdata.status == rrts_pkg::ST_RUN) begin
          if (p_first_r) begin
            // age the current task
            upd_wr = 1'b1;
            if (mem_rdata.sleep != 32'd0) begin
              upd.sleep = mem_rdata.sleep - 32'd1;
            end else begin
              upd.run_count = mem_rdata.run_count + 32'd1;
            end
          end else if (mem_rdata.sleep != 32'd0) begin
            upd_wr    = 1'b1;
            upd.sleep = mem_rdata.sleep - 32'd1;
          end else begin
            upd_hit = 1'b1;
          end
        end
      end
      rrts_pkg::CMD_ALLOC: begin
        if (mem_rdata.status != rrts_pkg::ST_RUN && mem_rdata.status != rrts_pkg::ST_SUSP) begin
          upd_wr        = 1'b1;
          upd_hit       = 1'b1;
          upd.status    = rrts_pkg::ST_SUSP;
          upd.sleep     = '0;
          upd.run_count = '0;
          upd.pid       = pid_r;
        end
      end
      rrts_pkg::CMD_PAUSE_TID, rrts_pkg::CMD_PAUSE_PID: begin
        if (mem_rdata.status == rrts_pkg::ST_RUN &&
            (cmd_r == rrts_pkg::CMD_PAUSE_TID || mem_rdata.pid == pid_r)) begin
          upd_wr     = 1'b1;
          upd_hit    = 1'b1;
          upd.status = rrts_pkg::ST_SUSP;
        end
      end
      rrts_pkg::CMD_RESUME_TID, rrts_pkg::CMD_RESUME_PID: begin
        if (mem_rdata.status == rrts_pkg::ST_SUSP &&
            (cmd_r == rrts_pkg::CMD_RESUME_TID || mem_rdata.pid == pid_r)) begin
          upd_wr     = 1'b1;
          upd_hit    = 1'b1;
          upd.status = rrts_pkg::ST_RUN;
        end
      end
      rrts_pkg::CMD_TERM_TID, rrts_pkg::CMD_TERM_PID: begin
        if (mem_rdata.status == rrts_pkg::ST_RUN &&
            (cmd_r == rrts_pkg::CMD_TERM_TID || mem_rdata.pid == pid_r)) begin
          upd_wr     = 1'b1;
          upd_hit    = 1'b1;
          upd.status = rrts_pkg::ST_FREE;
        end
      end
      rrts_pkg::CMD_SET_SLEEP: begin
        upd_wr    = 1'b1;
        upd_hit   = 1'b1;
        upd.sleep = sleep_r;
      end
      default: begin
      end
    endcase
  end

  assign stop = pv_r && (upd_hit || p_last_r);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    pid_nxt     = pid_r;
    sleep_nxt   = sleep_r;
    cur_nxt     = cur_r;
    cur_pid_nxt = cur_pid_r;
    addr_nxt    = addr_r;
    left_nxt    = left_r;
    first_nxt   = first_r;
    pv_nxt      = pv_r;
    p_addr_nxt  = p_addr_r;
    p_first_nxt = p_first_r;
    p_last_nxt  = p_last_r;
    hit_nxt     = hit_r;
    hit_vld_nxt = hit_vld_r;
    clr_nxt     = clr_r;
    mem_ctl     = '0;
    mem_waddr   = p_addr_r;
    mem_wdata   = upd;
    mem_raddr   = addr_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;

    unique case (state_r)
      rrts_pkg::S_CLEAR: begin
        mem_ctl.wr_en    = 1'b1;
        mem_waddr        = clr_r;
        mem_wdata        = '0;
        mem_wdata.status = (clr_r == '0) ? rrts_pkg::ST_RUN : rrts_pkg::ST_FREE;
        if (clr_r == LAST_IDX) begin
          state_nxt = rrts_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + IDX_W'(1);
        end
      end
      rrts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt     = in_cmd_e;
          pid_nxt     = in_pid;
          sleep_nxt   = in_sleep;
          hit_nxt     = '0;
          hit_vld_nxt = 1'b0;
          first_nxt   = 1'b1;
          pv_nxt      = 1'b0;
          case (in_cmd_e) inside
            rrts_pkg::CMD_TICK: begin
              addr_nxt  = cur_r;
              left_nxt  = CNT_W'(NUM_TASKS);
              state_nxt = rrts_pkg::S_SCAN;
            end
            rrts_pkg::CMD_ALLOC, rrts_pkg::CMD_PAUSE_PID, rrts_pkg::CMD_RESUME_PID,
            rrts_pkg::CMD_TERM_PID: begin
              addr_nxt  = '0;
              left_nxt  = CNT_W'(NUM_TASKS);
              state_nxt = rrts_pkg::S_SCAN;
            end
            rrts_pkg::CMD_PAUSE_TID, rrts_pkg::CMD_RESUME_TID, rrts_pkg::CMD_TERM_TID,
            rrts_pkg::CMD_SET_SLEEP: begin
              if (tid_ok) begin
                addr_nxt  = IDX_W'(in_slot);
                left_nxt  = CNT_W'(1);
                state_nxt = rrts_pkg::S_SCAN;
              end else begin
                state_nxt = rrts_pkg::S_RESP;
              end
            end
            default: begin
              state_nxt = rrts_pkg::S_RESP;
            end
          endcase
        end
      end
      rrts_pkg::S_SCAN: begin
        if (pv_r && upd_wr) begin
          mem_ctl.wr_en = 1'b1;
          if (p_addr_r == cur_r) begin
            cur_pid_nxt = upd.pid;
          end
        end
        if (pv_r && upd_hit) begin
          hit_vld_nxt = 1'b1;
          hit_nxt     = p_addr_r;
          if (cmd_r == rrts_pkg::CMD_TICK) begin
            cur_nxt     = p_addr_r;
            cur_pid_nxt = mem_rdata.pid;
          end
        end
        if (stop) begin
          pv_nxt    = 1'b0;
          state_nxt = rrts_pkg::S_RESP;
        end else if (left_r != '0) begin
          mem_ctl.rd_en = 1'b1;
          pv_nxt        = 1'b1;
          p_addr_nxt    = addr_r;
          p_first_nxt   = first_r;
          p_last_nxt    = (left_r == CNT_W'(1));
          first_nxt     = 1'b0;
          left_nxt      = left_r - CNT_W'(1);
          addr_nxt      = (addr_r == LAST_IDX) ? '0 : addr_r + IDX_W'(1);
        end else begin
          pv_nxt = 1'b0;
        end
      end
      rrts_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = rrts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rrts_pkg::S_CLEAR;
      end
    endcase
  end

  assign res.success  = hit_vld_r;
  assign res.hit_slot = hit_vld_r ? 6'(hit_r) : 6'd0;
  assign res.cur_slot = 6'(cur_r);
  assign res.cur_pid  = cur_pid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rrts_pkg::S_CLEAR;
      clr_r     <= '0;
      cur_r     <= '0;
      cur_pid_r <= '0;
      pv_r      <= 1'b0;
      left_r    <= '0;
      first_r   <= 1'b0;
      hit_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      cur_r     <= cur_nxt;
      cur_pid_r <= cur_pid_nxt;
      pv_r      <= pv_nxt;
      left_r    <= left_nxt;
      first_r   <= first_nxt;
      hit_vld_r <= hit_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    pid_r     <= pid_nxt;
    sleep_r   <= sleep_nxt;
    addr_r    <= addr_nxt;
    p_addr_r  <= p_addr_nxt;
    p_first_r <= p_first_nxt;
    p_last_r  <= p_last_nxt;
    hit_r     <= hit_nxt;
  end

  a_no_same_entry_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.wr_en && mem_ctl.rd_en) |-> (mem_waddr != mem_raddr))
    else $error("table read and write hit the same entry in one cycle");

  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= LAST_IDX)
    else $error("current slot beyond table depth");

  a_pipe_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == rrts_pkg::S_SCAN))
    else $error("read pipeline live outside a scan");

  a_resp_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (state_r == rrts_pkg::S_IDLE))
    else $error("controller did not return to idle after a result");

endmodule

[tb/round_robin_task_scheduler_unit_tb.sv]
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit_tb: self-checking bench for the task scheduler
// Drive a short directed table through the stream input, then random command
// mixes under three idling profiles. Predict every result from a local copy of
// the task table and compare each result item, field by field, in order.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit_tb;

  localparam int NUM_TASKS   = 64;
  localparam int STALL_LIMIT = 5000;            // cycles without any handshake
  localparam int TAIL_CYCLES = NUM_TASKS + 16;  // longest walk plus margin
  localparam int HOLD_CYCLES = 400;             // long receiver hold-off
  localparam int ITEMS_PER_PHASE = 290;

  // Command codes the block leaves unused
  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  // Small pid pool so that pid lookups hit often
  localparam logic [0:5][15:0] PID_POOL = {
    16'h0000, 16'hFFFF, 16'hA5A5, 16'h5A5A, 16'h0001, 16'h8000
  };

  // One input item; packed with command in the low bits, as on in_tdata
  typedef struct packed {
    logic [31:0] ticks;
    logic [15:0] pid;
    logic [5:0]  slot;
    logic [3:0]  cmd;
  } sched_item_t;

  typedef struct packed {
    sched_item_t     item;
    logic            has_exp;
    rrts_pkg::res_t  exp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [3:0] command, [9:4] task_slot, [25:10] proc_id, [57:26] sleep_ticks,
  // [63:58] zero
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] success, [6:1] hit_slot, [12:7] current_slot, [28:13] current_pid,
  // [31:29] zero
  logic [31:0] out_tdata;

  // Local copy of the task table
  rrts_pkg::status_t tbl_status [NUM_TASKS];
  logic [31:0]       tbl_sleep  [NUM_TASKS];
  logic [31:0]       tbl_runs   [NUM_TASKS];
  logic [15:0]       tbl_pid    [NUM_TASKS];
  logic [5:0]        run_slot;

  rrts_pkg::res_t sched_results_q [$];   // results still owed by the block, oldest first
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_cycles = 0;

  round_robin_task_scheduler_unit #(
    .NUM_TASKS(NUM_TASKS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Table prediction
  // --------------------------------------------------------------------------

  // Lowest slot with the wanted status and pid, -1 if none
  function automatic int pid_lookup(logic [15:0] pid, rrts_pkg::status_t want);
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (tbl_status[i] == want && tbl_pid[i] == pid) return i;
    end
    return -1;
  endfunction

  // A 6-bit slot is always inside a 64-entry table; only the status matters
  function automatic int tid_lookup(logic [5:0] slot, rrts_pkg::status_t want);
    return (tbl_status[slot] == want) ? int'(slot) : -1;
  endfunction

  // Apply one item to the local table and return the result it must produce
  function automatic rrts_pkg::res_t schedule_step(sched_item_t it);
    int             hit;
    int             idx;
    rrts_pkg::res_t r;
    hit = -1;
    case (it.cmd)
      rrts_pkg::CMD_TICK: begin
        // Age the current task only while it is runnable
        if (tbl_status[run_slot] == rrts_pkg::ST_RUN) begin
          if (tbl_sleep[run_slot] != 0) tbl_sleep[run_slot]--;
          else tbl_runs[run_slot]++;
        end
        // Walk the other slots; sleepers passed over lose one tick each
        for (int k = 1; k < NUM_TASKS && hit < 0; k++) begin
          idx = (int'(run_slot) + k) % NUM_TASKS;
          if (tbl_status[idx] == rrts_pkg::ST_RUN) begin
            if (tbl_sleep[idx] != 0) tbl_sleep[idx]--;
            else hit = idx;
          end
        end
        if (hit >= 0) run_slot = 6'(hit);
      end
      rrts_pkg::CMD_ALLOC: begin
        for (int i = 0; i < NUM_TASKS && hit < 0; i++) begin
          if (tbl_status[i] != rrts_pkg::ST_RUN && tbl_status[i] != rrts_pkg::ST_SUSP) begin
            tbl_status[i] = rrts_pkg::ST_SUSP;
            tbl_sleep[i]  = '0;
            tbl_runs[i]   = '0;
            tbl_pid[i]    = it.pid;
            hit = i;
          end
        end
      end
      rrts_pkg::CMD_PAUSE_TID, rrts_pkg::CMD_PAUSE_PID: begin
        hit = (it.cmd == rrts_pkg::CMD_PAUSE_TID) ? tid_lookup(it.slot, rrts_pkg::ST_RUN)
                                                  : pid_lookup(it.pid, rrts_pkg::ST_RUN);
        if (hit >= 0) tbl_status[hit] = rrts_pkg::ST_SUSP;
      end
      rrts_pkg::CMD_RESUME_TID, rrts_pkg::CMD_RESUME_PID: begin
        hit = (it.cmd == rrts_pkg::CMD_RESUME_TID) ? tid_lookup(it.slot, rrts_pkg::ST_SUSP)
                                                   : pid_lookup(it.pid, rrts_pkg::ST_SUSP);
        if (hit >= 0) tbl_status[hit] = rrts_pkg::ST_RUN;
      end
      rrts_pkg::CMD_TERM_TID, rrts_pkg::CMD_TERM_PID: begin
        // Terminating the current task leaves run_slot where it is
        hit = (it.cmd == rrts_pkg::CMD_TERM_TID) ? tid_lookup(it.slot, rrts_pkg::ST_RUN)
                                                 : pid_lookup(it.pid, rrts_pkg::ST_RUN);
        if (hit >= 0) tbl_status[hit] = rrts_pkg::ST_FREE;
      end
      rrts_pkg::CMD_SET_SLEEP: begin
        tbl_sleep[it.slot] = it.ticks;
        hit = int'(it.slot);
      end
      default: ;  // unused codes change nothing
    endcase
    r.success  = (hit >= 0);
    r.hit_slot = (hit >= 0) ? 6'(hit) : 6'd0;
    r.cur_slot = run_slot;
    r.cur_pid  = tbl_pid[run_slot];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic dir_row_t mk_row(logic [3:0] cmd, logic [5:0] slot,
                                      logic [15:0] pid, logic [31:0] ticks,
                                      bit has_exp, logic ok, logic [5:0] hit,
                                      logic [5:0] cur, logic [15:0] cpid);
    dir_row_t row;
    row.item.cmd      = cmd;
    row.item.slot     = slot;
    row.item.pid      = pid;
    row.item.ticks    = ticks;
    row.has_exp       = has_exp;
    row.exp.success   = ok;
    row.exp.hit_slot  = hit;
    row.exp.cur_slot  = cur;
    row.exp.cur_pid   = cpid;
    return row;
  endfunction

  // Random item: mostly low slots and pooled pids, so lookups land
  function automatic sched_item_t draw_item();
    sched_item_t it;
    int          pick;
    pick    = $urandom_range(99);
    it.slot = ($urandom_range(99) < 80) ? 6'($urandom_range(15))
                                        : 6'($urandom_range(63));
    it.pid  = ($urandom_range(99) < 85) ? PID_POOL[$urandom_range(5)]
                                        : 16'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: it.ticks = $urandom_range(3);
      7, 8:                it.ticks = $urandom_range(40, 4);
      default:             it.ticks = $urandom;
    endcase
    if (pick < 35)      it.cmd = rrts_pkg::CMD_TICK;
    else if (pick < 45) it.cmd = rrts_pkg::CMD_ALLOC;
    else if (pick < 53) it.cmd = rrts_pkg::CMD_RESUME_TID;
    else if (pick < 59) it.cmd = rrts_pkg::CMD_RESUME_PID;
    else if (pick < 64) it.cmd = rrts_pkg::CMD_PAUSE_TID;
    else if (pick < 68) it.cmd = rrts_pkg::CMD_PAUSE_PID;
    else if (pick < 73) it.cmd = rrts_pkg::CMD_TERM_TID;
    else if (pick < 77) it.cmd = rrts_pkg::CMD_TERM_PID;
    else if (pick < 93) it.cmd = rrts_pkg::CMD_SET_SLEEP;
    else                it.cmd = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    return it;
  endfunction

  // Offer one item; hold it until accepted, then record what it must produce.
  // Called at a falling edge and returns at a falling edge.
  task automatic push_item(input sched_item_t it, input bit has_exp,
                           input rrts_pkg::res_t exp);
    rrts_pkg::res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'b0, it};
    do @(posedge clk); while (!in_tready);
    pred = schedule_step(it);
    sched_results_q.push_back(has_exp ? exp : pred);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rrts_pkg::res_t got;
    rrts_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = rrts_pkg::res_t'(out_tdata[28:0]);
      if (sched_results_q.size() == 0) begin
        $error("result item with none expected: out_tdata=%h", out_tdata);
        fail_count++;
      end else begin
        want = sched_results_q.pop_front();
        if (got.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, got.success);
          fail_count++;
        end
        if (got.hit_slot !== want.hit_slot) begin
          $error("hit_slot: expected %0d, got %0d", want.hit_slot, got.hit_slot);
          fail_count++;
        end
        if (got.cur_slot !== want.cur_slot) begin
          $error("current_slot: expected %0d, got %0d", want.cur_slot, got.cur_slot);
          fail_count++;
        end
        if (got.cur_pid !== want.cur_pid) begin
          $error("current_pid: expected %h, got %h", want.cur_pid, got.cur_pid);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no item moves on either side for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t    rows [$];
    sched_item_t it;

    // Directed table. Expected values are typed where they follow directly
    // from the reset table; the sleep-draining ticks rely on the predictor.
    rows = '{
      // tick with only slot 0 runnable: no switch
      mk_row(rrts_pkg::CMD_TICK, 6'd0, 16'h0000, 32'h0, 1, 1'b0, 6'd0, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_ALLOC, 6'd0, 16'hFFFF, 32'h0, 1, 1'b1, 6'd1, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_ALLOC, 6'd0, 16'h0000, 32'h0, 1, 1'b1, 6'd2, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_RESUME_TID, 6'd1, 16'h0000, 32'h0, 1, 1'b1, 6'd1, 6'd0, 16'h0000),
      // tick switches to the freshly resumed slot
      mk_row(rrts_pkg::CMD_TICK, 6'd0, 16'h0000, 32'h0, 1, 1'b1, 6'd1, 6'd1, 16'hFFFF),
      mk_row(rrts_pkg::CMD_SET_SLEEP, 6'd0, 16'h0000, 32'hFFFFFFFF,
             1, 1'b1, 6'd0, 6'd1, 16'hFFFF),
      // only runnable peer is asleep: full wrap, current task stays
      mk_row(rrts_pkg::CMD_TICK, 6'd0, 16'h0000, 32'h0, 0, 1'b0, 6'd0, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_PAUSE_TID, 6'd1, 16'h0000, 32'h0, 1, 1'b1, 6'd1, 6'd1, 16'hFFFF),
      // current task suspended: not aged
      mk_row(rrts_pkg::CMD_TICK, 6'd0, 16'h0000, 32'h0, 0, 1'b0, 6'd0, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_SET_SLEEP, 6'd0, 16'h0000, 32'h0, 1, 1'b1, 6'd0, 6'd1, 16'hFFFF),
      mk_row(rrts_pkg::CMD_TICK, 6'd0, 16'h0000, 32'h0, 0, 1'b0, 6'd0, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_RESUME_PID, 6'd0, 16'hFFFF, 32'h0, 1, 1'b1, 6'd1, 6'd0, 16'h0000),
      // pid lookups take the lowest matching slot
      mk_row(rrts_pkg::CMD_PAUSE_PID, 6'd0, 16'h0000, 32'h0, 1, 1'b1, 6'd0, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_RESUME_PID, 6'd0, 16'h0000, 32'h0, 1, 1'b1, 6'd0, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_TERM_PID, 6'd0, 16'hFFFF, 32'h0, 1, 1'b1, 6'd1, 6'd0, 16'h0000),
      // misses by task id
      mk_row(rrts_pkg::CMD_TERM_TID, 6'd63, 16'h0000, 32'h0, 1, 1'b0, 6'd0, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_PAUSE_TID, 6'd63, 16'h0000, 32'h0, 1, 1'b0, 6'd0, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_RESUME_TID, 6'd0, 16'h0000, 32'h0, 1, 1'b0, 6'd0, 6'd0, 16'h0000),
      // unused code with every field at its top value
      mk_row(CMD_UNUSED_HI, 6'd63, 16'hFFFF, 32'hFFFFFFFF, 1, 1'b0, 6'd0, 6'd0, 16'h0000),
      // terminate the current task: run_slot stays put
      mk_row(rrts_pkg::CMD_TERM_TID, 6'd0, 16'h0000, 32'h0, 1, 1'b1, 6'd0, 6'd0, 16'h0000),
      // current task free: not aged, nothing runnable
      mk_row(rrts_pkg::CMD_TICK, 6'd0, 16'h0000, 32'h0, 1, 1'b0, 6'd0, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_RESUME_TID, 6'd2, 16'h0000, 32'h0, 1, 1'b1, 6'd2, 6'd0, 16'h0000),
      mk_row(rrts_pkg::CMD_TICK, 6'd0, 16'h0000, 32'h0, 1, 1'b1, 6'd2, 6'd2, 16'h0000),
      // set sleep on a free slot still succeeds
      mk_row(rrts_pkg::CMD_SET_SLEEP, 6'd63, 16'h0000, 32'h5A5A5A5A,
             1, 1'b1, 6'd63, 6'd2, 16'h0000),
      // allocation reuses the lowest freed slot
      mk_row(rrts_pkg::CMD_ALLOC, 6'd0, 16'h1234, 32'h0, 1, 1'b1, 6'd0, 6'd2, 16'h0000)
    };

    // Reset image of the table
    for (int i = 0; i < NUM_TASKS; i++) begin
      tbl_status[i] = rrts_pkg::ST_FREE;
      tbl_sleep[i]  = '0;
      tbl_runs[i]   = '0;
      tbl_pid[i]    = '0;
    end
    tbl_status[0] = rrts_pkg::ST_RUN;
    run_slot      = '0;

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) push_item(rows[i].item, rows[i].has_exp, rows[i].exp);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct <= 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct <= 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Block the receiver for a long stretch while items keep coming
        if (ph == 0 && n == 60) hold_reqs <= hold_reqs + 1;
        // Stop sending until the block has delivered everything owed
        if (ph == 1 && n == 120) begin
          in_tvalid = 1'b0;
          while (sched_results_q.size() != 0) @(negedge clk);
        end
        // Fill the whole table, then run past it with allocations that miss
        if (ph == 2 && n == 100) begin
          repeat (NUM_TASKS + 4) begin
            it      = draw_item();
            it.cmd  = rrts_pkg::CMD_ALLOC;
            it.pid  = 16'($urandom);
            push_item(it, 1'b0, '0);
          end
        end
        push_item(draw_item(), 1'b0, '0);
      end
    end

    // Drain: wait for every owed result, then watch for strays
    in_tvalid = 1'b0;
    while (sched_results_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
